// ----- src/bsc_pkg.sv -----
// bsc_pkg: shared types, widths, codes and the microcode table of the safety checker
// no dependencies
package bsc_pkg;

    localparam int MAX_PROCS   = 8;
    localparam int MAX_RES     = 4;
    localparam int UNIT_BITS   = 8;
    localparam int WORK_BITS   = UNIT_BITS + 4;
    localparam int PROC_BITS   = $clog2(MAX_PROCS);
    localparam int RES_BITS    = $clog2(MAX_RES);
    localparam int ADDR_BITS   = PROC_BITS + RES_BITS;
    localparam int MAT_DEPTH   = MAX_PROCS * MAX_RES;
    localparam int PCOUNT_BITS = 4;
    localparam int RCOUNT_BITS = 3;
    localparam int CFG_BITS    = 4;
    localparam int STEP_BITS   = 4;

    localparam logic [1:0] FUNC_LOAD_ENTRY = 2'd0;
    localparam logic [1:0] FUNC_LOAD_AVAIL = 2'd1;
    localparam logic [1:0] FUNC_RUN        = 2'd2;

    localparam logic CFG_PROC_COUNT = 1'b0;
    localparam logic CFG_RES_COUNT  = 1'b1;

    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t ST_IDLE   = 4'd0;
    localparam step_t ST_INIT   = 4'd1;
    localparam step_t ST_PROC   = 4'd2;
    localparam step_t ST_READ   = 4'd3;
    localparam step_t ST_CMP    = 4'd4;
    localparam step_t ST_GRANT  = 4'd5;
    localparam step_t ST_NEXT   = 4'd6;
    localparam step_t ST_PASS   = 4'd7;
    localparam step_t ST_AGAIN  = 4'd8;
    localparam step_t ST_SAFE   = 4'd9;
    localparam step_t ST_UNSAFE = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_INIT,
        OP_PROC,
        OP_READ,
        OP_CMP,
        OP_GRANT,
        OP_NEXT,
        OP_PASS,
        OP_SAFE,
        OP_UNSAFE
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_START,
        COND_FINISHED,
        COND_RJ_MORE,
        COND_PI_MORE,
        COND_NOT_FOUND,
        COND_MORE_GRANT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  wait_out;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic finished;
        logic rj_more;
        logic pi_more;
        logic not_found;
        logic more_grant;
        logic out_free;
    } dp_flags_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            ST_IDLE:   w = '{OP_IDLE,   COND_NOT_START,  1'b0, ST_IDLE};
            ST_INIT:   w = '{OP_INIT,   COND_NEVER,      1'b0, ST_IDLE};
            ST_PROC:   w = '{OP_PROC,   COND_FINISHED,   1'b0, ST_NEXT};
            ST_READ:   w = '{OP_READ,   COND_NEVER,      1'b0, ST_IDLE};
            ST_CMP:    w = '{OP_CMP,    COND_RJ_MORE,    1'b0, ST_READ};
            ST_GRANT:  w = '{OP_GRANT,  COND_NEVER,      1'b1, ST_IDLE};
            ST_NEXT:   w = '{OP_NEXT,   COND_PI_MORE,    1'b0, ST_PROC};
            ST_PASS:   w = '{OP_PASS,   COND_NOT_FOUND,  1'b0, ST_UNSAFE};
            ST_AGAIN:  w = '{OP_NOP,    COND_MORE_GRANT, 1'b0, ST_PROC};
            ST_SAFE:   w = '{OP_SAFE,   COND_ALWAYS,     1'b1, ST_IDLE};
            ST_UNSAFE: w = '{OP_UNSAFE, COND_ALWAYS,     1'b1, ST_IDLE};
            default:   w = '{OP_NOP,    COND_ALWAYS,     1'b0, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/bsc_in_if.sv -----
// bsc_in_if: input item channel of the safety checker
// depends on bsc_pkg
interface bsc_in_if import bsc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [PROC_BITS-1:0] proc_index;
    logic [RES_BITS-1:0]  res_index;
    logic [UNIT_BITS-1:0] held_units;
    logic [UNIT_BITS-1:0] max_units;
    logic [UNIT_BITS-1:0] free_units;

    modport source (output valid, func, proc_index, res_index, held_units, max_units,
                    free_units, input ready);
    modport sink (input valid, func, proc_index, res_index, held_units, max_units,
                  free_units, output ready);
endinterface

// ----- src/bsc_out_if.sv -----
// bsc_out_if: result channel of the safety checker
// depends on bsc_pkg
interface bsc_out_if import bsc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 is_verdict;
    logic [PROC_BITS-1:0] granted_proc;
    logic                 is_safe;
    logic                 last;

    modport source (output valid, is_verdict, granted_proc, is_safe, last, input ready);
    modport sink (input valid, is_verdict, granted_proc, is_safe, last, output ready);
endinterface

// ----- src/bsc_cfg_if.sv -----
// bsc_cfg_if: register write channel of the safety checker
// depends on bsc_pkg
interface bsc_cfg_if import bsc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                index;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/bankers_safety_check.sv -----
// bankers_safety_check: top level of the deadlock-avoidance safety checker
// depends on bsc_pkg, the channel interfaces, bsc_seq and bsc_datapath
//
// Load items (held/maximum entry, available entry) are taken one per cycle while idle and
// produce no result. A run item is worked by a microcoded sequencer over one single-port
// matrix ram, one entry at a time: after the accepting step an init step; per process a
// step that skips it if finished, else reads and compares its entries and tries a grant,
// and a step to the next process; per pass a pass step, and one deciding on another pass
// if it granted a process; last a verdict step. Grant and verdict steps wait while the
// result register is full. Input stays stalled until the run's verdict is issued; each
// result is held in a single output register so the next grant can go on while it waits.
module bankers_safety_check import bsc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bsc_in_if.sink    in_ch,
    bsc_out_if.source out_ch,
    bsc_cfg_if.sink   cfg
);

    op_t       op;
    dp_flags_t flags;

    bsc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    bsc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .flags  (flags),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

endmodule

// ----- src/bsc_ram.sv -----
// bsc_ram: generic single-port ram with registered read
// no dependencies
module bsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bsc_seq.sv -----
// bsc_seq: step counter and microcode table that drive the datapath
// depends on bsc_pkg
module bsc_seq import bsc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  dp_flags_t flags,
    output op_t       op
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   stall;
    logic   take;

    always_comb
    begin
        uw    = ucode(step_reg);
        stall = uw.wait_out && !flags.out_free;
        case (uw.cond)
            COND_NEVER:      take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_NOT_START:  take = !flags.start;
            COND_FINISHED:   take = flags.finished;
            COND_RJ_MORE:    take = flags.rj_more;
            COND_PI_MORE:    take = flags.pi_more;
            COND_NOT_FOUND:  take = flags.not_found;
            COND_MORE_GRANT: take = flags.more_grant;
            default:         take = 1'b0;
        endcase
        op = stall ? OP_NOP : uw.op;
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- src/bsc_datapath.sv -----
// bsc_datapath: matrices, work vector, finished flags, counters and result register
// depends on bsc_pkg, bsc_ram and the channel interfaces
module bsc_datapath import bsc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    output dp_flags_t  flags,
    bsc_in_if.sink     in_ch,
    bsc_out_if.source  out_ch,
    bsc_cfg_if.sink    cfg
);

    logic [PCOUNT_BITS-1:0] proc_count_reg;
    logic [RCOUNT_BITS-1:0] res_count_reg;
    logic [UNIT_BITS-1:0]   avail_reg [MAX_RES];
    logic [WORK_BITS-1:0]   work_reg [MAX_RES];
    logic [WORK_BITS-1:0]   work_next [MAX_RES];
    logic [UNIT_BITS-1:0]   held_buf_reg [MAX_RES];
    logic [MAX_PROCS-1:0]   finished_reg;
    logic [MAX_PROCS-1:0]   finished_next;
    logic [PCOUNT_BITS-1:0] granted_reg;
    logic [PCOUNT_BITS-1:0] granted_next;
    logic [PROC_BITS-1:0]   pi_reg;
    logic [PROC_BITS-1:0]   pi_next;
    logic [RES_BITS-1:0]    rj_reg;
    logic [RES_BITS-1:0]    rj_next;
    logic                   fit_reg;
    logic                   fit_next;
    logic                   found_reg;
    logic                   found_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_verdict_reg;
    logic [PROC_BITS-1:0]   out_proc_reg;
    logic                   out_safe_reg;

    logic [PCOUNT_BITS-1:0] np_eff;
    logic [RCOUNT_BITS-1:0] nr_eff;
    logic                   in_take;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [2*UNIT_BITS-1:0] ram_wdata;
    logic [2*UNIT_BITS-1:0] ram_rdata;
    logic [UNIT_BITS-1:0]   rd_held;
    logic [UNIT_BITS-1:0]   rd_max;
    logic [UNIT_BITS-1:0]   need;
    logic                   emit;
    logic                   emit_verdict;
    logic                   emit_safe;
    logic [WORK_BITS:0]     sum [MAX_RES];

    assign np_eff = (proc_count_reg == '0) ? PCOUNT_BITS'(1)
                  : (proc_count_reg > PCOUNT_BITS'(MAX_PROCS)) ? PCOUNT_BITS'(MAX_PROCS)
                  : proc_count_reg;
    assign nr_eff = (res_count_reg == '0) ? RCOUNT_BITS'(1)
                  : (res_count_reg > RCOUNT_BITS'(MAX_RES)) ? RCOUNT_BITS'(MAX_RES)
                  : res_count_reg;

    assign in_ch.ready = (op == OP_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    assign ram_we    = in_take && (in_ch.func == FUNC_LOAD_ENTRY);
    assign ram_addr  = ram_we ? {in_ch.proc_index, in_ch.res_index} : {pi_reg, rj_reg};
    assign ram_wdata = {in_ch.held_units, in_ch.max_units};

    bsc_ram #(
        .WIDTH (2 * UNIT_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_held = ram_rdata[2*UNIT_BITS-1:UNIT_BITS];
    assign rd_max  = ram_rdata[UNIT_BITS-1:0];
    assign need    = (rd_max > rd_held) ? (rd_max - rd_held) : '0;

    assign flags.start      = in_take && (in_ch.func == FUNC_RUN);
    assign flags.finished   = finished_reg[pi_reg];
    assign flags.rj_more    = (rj_reg != RES_BITS'(nr_eff - RCOUNT_BITS'(1)));
    assign flags.pi_more    = (pi_reg != PROC_BITS'(np_eff - PCOUNT_BITS'(1)));
    assign flags.not_found  = !found_reg;
    assign flags.more_grant = (granted_reg != np_eff);
    assign flags.out_free   = !out_valid_reg || out_ch.ready;

    assign emit         = ((op == OP_GRANT) && fit_reg) || (op == OP_SAFE) || (op == OP_UNSAFE);
    assign emit_verdict = (op == OP_SAFE) || (op == OP_UNSAFE);
    assign emit_safe    = (op == OP_SAFE);

    always_comb
    begin
        for (int j = 0; j < MAX_RES; j++)
        begin
            sum[j]       = {1'b0, work_reg[j]} + (WORK_BITS + 1)'(held_buf_reg[j]);
            work_next[j] = work_reg[j];
        end
        finished_next  = finished_reg;
        granted_next   = granted_reg;
        pi_next        = pi_reg;
        rj_next        = rj_reg;
        fit_next       = fit_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        case (op)
            OP_INIT:
            begin
                for (int j = 0; j < MAX_RES; j++)
                begin
                    work_next[j] = (j < int'(nr_eff)) ? WORK_BITS'(avail_reg[j]) : '0;
                end
                finished_next = '0;
                granted_next  = '0;
                pi_next       = '0;
                found_next    = 1'b0;
            end
            OP_PROC:
            begin
                rj_next  = '0;
                fit_next = 1'b1;
            end
            OP_CMP:
            begin
                if (WORK_BITS'(need) > work_reg[rj_reg])
                begin
                    fit_next = 1'b0;
                end
                rj_next = rj_reg + RES_BITS'(1);
            end
            OP_GRANT:
            begin
                if (fit_reg)
                begin
                    for (int j = 0; j < MAX_RES; j++)
                    begin
                        if (j < int'(nr_eff))
                        begin
                            work_next[j] = sum[j][WORK_BITS] ? '1 : sum[j][WORK_BITS-1:0];
                        end
                    end
                    finished_next[pi_reg] = 1'b1;
                    granted_next          = granted_reg + PCOUNT_BITS'(1);
                    found_next            = 1'b1;
                end
            end
            OP_NEXT:
            begin
                pi_next = pi_reg + PROC_BITS'(1);
            end
            OP_PASS:
            begin
                pi_next    = '0;
                found_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_count_reg <= PCOUNT_BITS'(MAX_PROCS);
            res_count_reg  <= RCOUNT_BITS'(MAX_RES);
            for (int j = 0; j < MAX_RES; j++)
            begin
                work_reg[j] <= '0;
            end
            finished_reg  <= '0;
            granted_reg   <= '0;
            pi_reg        <= '0;
            rj_reg        <= '0;
            fit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_PROC_COUNT)
                begin
                    proc_count_reg <= cfg.data[PCOUNT_BITS-1:0];
                end
                else if (cfg.index == CFG_RES_COUNT)
                begin
                    res_count_reg <= cfg.data[RCOUNT_BITS-1:0];
                end
            end
            for (int j = 0; j < MAX_RES; j++)
            begin
                work_reg[j] <= work_next[j];
            end
            finished_reg  <= finished_next;
            granted_reg   <= granted_next;
            pi_reg        <= pi_next;
            rj_reg        <= rj_next;
            fit_reg       <= fit_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take && (in_ch.func == FUNC_LOAD_AVAIL))
        begin
            avail_reg[in_ch.res_index] <= in_ch.free_units;
        end
        if (op == OP_CMP)
        begin
            held_buf_reg[rj_reg] <= rd_held;
        end
        if (emit)
        begin
            out_verdict_reg <= emit_verdict;
            out_proc_reg    <= emit_verdict ? '0 : pi_reg;
            out_safe_reg    <= emit_safe;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.is_verdict   = out_verdict_reg;
    assign out_ch.granted_proc = out_proc_reg;
    assign out_ch.is_safe      = out_safe_reg;
    assign out_ch.last         = out_verdict_reg;

endmodule

// ----- tb/sv/bsc_grant_verifier.sv -----
// bsc_grant_verifier: watches the load, register and result channels of the safety checker,
// predicts the safe sequence and verdict of every run and compares each result transfer
// depends on bsc_pkg and the channel interfaces
`timescale 1ns / 1ps

module bsc_grant_verifier import bsc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bsc_in_if    in_ch,
    bsc_out_if   out_ch,
    bsc_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    localparam int WORK_MAX = (1 << WORK_BITS) - 1;

    typedef struct packed {
        logic                 is_verdict;
        logic [PROC_BITS-1:0] granted_proc;
        logic                 is_safe;
        logic                 last;
    } grant_rec_t;

    logic [UNIT_BITS-1:0]   held_tab  [MAT_DEPTH];
    logic [UNIT_BITS-1:0]   max_tab   [MAT_DEPTH];
    logic [UNIT_BITS-1:0]   avail_tab [MAX_RES];
    logic [PCOUNT_BITS-1:0] proc_cnt;
    logic [RCOUNT_BITS-1:0] res_cnt;
    grant_rec_t             expected_grants [$];
    grant_rec_t             want;
    int                     errors;

    initial
    begin
        errors     = 0;
        fail_count = 0;
        pending    = 0;
    end

    function automatic void run_safety_check();
        int         np;
        int         nr;
        int         granted;
        int         need;
        int         work [MAX_RES];
        bit         done [MAX_PROCS];
        bit         found;
        bit         fits;
        grant_rec_t rec;
        np = (proc_cnt == 0) ? 1 : (proc_cnt > MAX_PROCS) ? MAX_PROCS : int'(proc_cnt);
        nr = (res_cnt == 0) ? 1 : (res_cnt > MAX_RES) ? MAX_RES : int'(res_cnt);
        for (int j = 0; j < MAX_RES; j++)
            work[j] = (j < nr) ? int'(avail_tab[j]) : 0;
        for (int i = 0; i < MAX_PROCS; i++)
            done[i] = 1'b0;
        granted = 0;
        found = 1'b1;
        while (granted < np && found)
        begin
            found = 1'b0;
            for (int i = 0; i < np; i++)
            begin
                if (!done[i])
                begin
                    fits = 1'b1;
                    for (int j = 0; j < nr; j++)
                    begin
                        need = int'(max_tab[i * MAX_RES + j]) - int'(held_tab[i * MAX_RES + j]);
                        if (need > work[j])
                            fits = 1'b0;
                    end
                    if (fits)
                    begin
                        for (int j = 0; j < nr; j++)
                        begin
                            work[j] = work[j] + int'(held_tab[i * MAX_RES + j]);
                            if (work[j] > WORK_MAX)
                                work[j] = WORK_MAX;
                        end
                        done[i] = 1'b1;
                        granted++;
                        found = 1'b1;
                        rec = '{1'b0, PROC_BITS'(i), 1'b0, 1'b0};
                        expected_grants.push_back(rec);
                    end
                end
            end
        end
        rec = '{1'b1, '0, (granted == np), 1'b1};
        expected_grants.push_back(rec);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_cnt = PCOUNT_BITS'(MAX_PROCS);
            res_cnt  = RCOUNT_BITS'(MAX_RES);
            expected_grants.delete();
            pending  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_PROC_COUNT)
                    proc_cnt = cfg.data;
                else if (cfg.index == CFG_RES_COUNT)
                    res_cnt = cfg.data[RCOUNT_BITS-1:0];
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.func)
                    FUNC_LOAD_ENTRY:
                    begin
                        held_tab[{in_ch.proc_index, in_ch.res_index}] = in_ch.held_units;
                        max_tab[{in_ch.proc_index, in_ch.res_index}]  = in_ch.max_units;
                    end
                    FUNC_LOAD_AVAIL: avail_tab[in_ch.res_index] = in_ch.free_units;
                    FUNC_RUN:        run_safety_check();
                    default:         ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %b %0d %b %b",
                             $time, out_ch.is_verdict, out_ch.granted_proc, out_ch.is_safe,
                             out_ch.last);
                    errors++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    check_field("is_verdict", 8'(want.is_verdict), 8'(out_ch.is_verdict));
                    check_field("granted_proc", 8'(want.granted_proc),
                                8'(out_ch.granted_proc));
                    check_field("is_safe", 8'(want.is_safe), 8'(out_ch.is_safe));
                    check_field("last", 8'(want.last), 8'(out_ch.last));
                end
            end
            pending <= expected_grants.size();
        end
        fail_count <= errors;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: drives loads, runs and register writes into bankers_safety_check with random
// gaps and result stalls; bsc_grant_verifier does the checking, this module gives the verdict
// depends on bsc_pkg, the channel interfaces, bankers_safety_check and bsc_grant_verifier
`timescale 1ns / 1ps

module testbench;
    import bsc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         RAND_ITEMS  = 370;
    localparam int         QUIET_TAIL  = 60;

    typedef enum int {MODE_SMALL, MODE_FULL, MODE_EXTREME} fill_mode_t;

    logic       clk;
    logic       rst_n;
    bit         idle_on;
    int         stall_left;
    int         fail_count;
    int         pending;
    int         item_total;
    int         cur_np;
    int         cur_nr;
    int         guard;
    fill_mode_t mode;

    bsc_in_if  in_ch();
    bsc_out_if out_ch();
    bsc_cfg_if cfg();

    bankers_safety_check dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    bsc_grant_verifier verifier (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result side stalls in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    function automatic logic [UNIT_BITS-1:0] pick_units(input fill_mode_t m);
        case (m)
            MODE_SMALL:   return UNIT_BITS'($urandom_range(0, 7));
            MODE_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default:      return UNIT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [PROC_BITS-1:0] rnd_proc();
        return PROC_BITS'($urandom);
    endfunction

    function automatic logic [RES_BITS-1:0] rnd_res();
        return RES_BITS'($urandom);
    endfunction

    function automatic logic [UNIT_BITS-1:0] rnd_unit();
        return UNIT_BITS'($urandom);
    endfunction

    task automatic send_item(input logic [1:0] fn, input logic [PROC_BITS-1:0] p,
                             input logic [RES_BITS-1:0] r, input logic [UNIT_BITS-1:0] h,
                             input logic [UNIT_BITS-1:0] m, input logic [UNIT_BITS-1:0] a);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= fn;
        in_ch.proc_index <= p;
        in_ch.res_index  <= r;
        in_ch.held_units <= h;
        in_ch.max_units  <= m;
        in_ch.free_units <= a;
        do @(posedge clk); while (!in_ch.ready);
        if (fn != FUNC_UNUSED)
            item_total++;
    endtask

    // drain all results, let the block go idle, then write both counts
    task automatic program_counts(input logic [CFG_BITS-1:0] pc, input logic [CFG_BITS-1:0] rc);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_PROC_COUNT;
        cfg.data  <= pc;
        do @(posedge clk); while (!cfg.ready);
        cfg.index <= CFG_RES_COUNT;
        cfg.data  <= rc;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        cur_np = (pc == 0) ? 1 : (pc > MAX_PROCS) ? MAX_PROCS : int'(pc);
        cur_nr = (rc[2:0] == 0) ? 1 : (rc[2:0] > MAX_RES) ? MAX_RES : int'(rc[2:0]);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        stall_left       = 0;
        item_total       = 0;
        cur_np           = MAX_PROCS;
        cur_nr           = MAX_RES;
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_LOAD_ENTRY;
        in_ch.proc_index = '0;
        in_ch.res_index  = '0;
        in_ch.held_units = '0;
        in_ch.max_units  = '0;
        in_ch.free_units = '0;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_PROC_COUNT;
        cfg.data         = '0;
        out_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry written before the first run
        for (int p = 0; p < MAX_PROCS; p++)
            for (int r = 0; r < MAX_RES; r++)
                send_item(FUNC_LOAD_ENTRY, PROC_BITS'(p), RES_BITS'(r), 8'd0, 8'd0,
                          rnd_unit());
        for (int r = 0; r < MAX_RES; r++)
            send_item(FUNC_LOAD_AVAIL, rnd_proc(), RES_BITS'(r), rnd_unit(), rnd_unit(), 8'd0);

        // zero need everywhere, then a blocked last process, then freed by available
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        send_item(FUNC_LOAD_ENTRY, 3'd0, 2'd0, 8'd255, 8'd255, 8'd0);
        send_item(FUNC_LOAD_ENTRY, 3'd7, 2'd3, 8'd0, 8'd255, 8'd255);
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        send_item(FUNC_LOAD_AVAIL, 3'd7, 2'd3, 8'd0, 8'd0, 8'd255);
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        // maximum below held, and a need on the same resource that the other process's held units cover
        send_item(FUNC_LOAD_ENTRY, 3'd0, 2'd1, 8'd0, 8'd5, 8'd0);
        send_item(FUNC_LOAD_ENTRY, 3'd3, 2'd1, 8'd5, 8'd0, 8'd0);
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        send_item(FUNC_UNUSED, '1, '1, '1, '1, '1);
        // counts of zero and above the maximum
        program_counts(4'd0, 4'd0);
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        program_counts(4'd15, 4'd8);
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        program_counts(4'd9, 4'd7);
        send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());

        item_total = 0;
        while (item_total < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: mode = MODE_SMALL;
                5, 6, 7:       mode = MODE_FULL;
                default:       mode = MODE_EXTREME;
            endcase
            idle_on <= (item_total < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                program_counts(CFG_BITS'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                                                     : $urandom_range(1, 4)),
                               CFG_BITS'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0)
            begin
                for (int p = 0; p < cur_np; p++)
                    for (int r = 0; r < cur_nr; r++)
                        send_item(FUNC_LOAD_ENTRY, PROC_BITS'(p), RES_BITS'(r),
                                  pick_units(mode), pick_units(mode), rnd_unit());
                for (int r = 0; r < cur_nr; r++)
                    send_item(FUNC_LOAD_AVAIL, rnd_proc(), RES_BITS'(r), rnd_unit(),
                              rnd_unit(), pick_units(mode));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(0, 5))
                        0:       send_item(FUNC_LOAD_AVAIL, rnd_proc(), rnd_res(), rnd_unit(),
                                           rnd_unit(), pick_units(mode));
                        1:       send_item(FUNC_UNUSED, rnd_proc(), rnd_res(), rnd_unit(),
                                           rnd_unit(), rnd_unit());
                        default: send_item(FUNC_LOAD_ENTRY, rnd_proc(), rnd_res(),
                                           pick_units(mode), pick_units(mode), rnd_unit());
                    endcase
                end
            end
            if ($urandom_range(0, 7) != 0)
                send_item(FUNC_RUN, rnd_proc(), rnd_res(), rnd_unit(), rnd_unit(), rnd_unit());
        end

        in_ch.valid <= 1'b0;
        idle_on     <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (pending != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bsc_pkg.sv
src/bsc_in_if.sv
src/bsc_out_if.sv
src/bsc_cfg_if.sv
src/bsc_ram.sv
src/bsc_seq.sv
src/bsc_datapath.sv
src/bankers_safety_check.sv
tb/sv/bsc_grant_verifier.sv
tb/sv/testbench.sv
